[hdl/hdst_pkg.sv]
// shared types, constants and distance helpers for the hand dwell and swipe tracker
package hdst_pkg;

  localparam int unsigned CoordW = 13;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ThrW   = 7;

  localparam logic [4:0]  StepLim    = 5'd20;
  localparam logic [9:0]  StepLimSq  = 10'd400;
  localparam logic [4:0]  StillLim   = 5'd30;
  localparam logic [9:0]  StillLimSq = 10'd900;

  localparam logic [ThrW-1:0] DwellMax = 7'd127;
  localparam logic [ThrW-1:0] ThrMin   = 7'd10;
  localparam logic [ThrW-1:0] ThrMax   = 7'd100;
  localparam logic [ThrW-1:0] ThrReset = 7'd30;

  typedef enum logic [2:0] {
    GEST_NONE   = 3'd0,
    GEST_STABLE = 3'd1,
    GEST_RIGHT  = 3'd2,
    GEST_LEFT   = 3'd3,
    GEST_DOWN   = 3'd4,
    GEST_UP     = 3'd5
  } gesture_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pos_t;

  typedef struct packed {
    logic     trigger_ready;
    gesture_e gesture;
  } res_t;

  // signed difference b - a, one bit wider than a coordinate
  function automatic logic signed [DiffW-1:0] coord_diff(logic signed [CoordW-1:0] a,
                                                         logic signed [CoordW-1:0] b);
    logic signed [DiffW-1:0] ea;
    logic signed [DiffW-1:0] eb;
    ea = {a[CoordW-1], a};
    eb = {b[CoordW-1], b};
    return eb - ea;
  endfunction

  function automatic logic [DiffW-1:0] magnitude(logic signed [DiffW-1:0] d);
    logic [DiffW-1:0] m;
    m = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
    return m;
  endfunction

  // true when dx*dx + dy*dy < lim_sq, lim being the root of lim_sq rounded up
  function automatic logic within_radius(logic signed [DiffW-1:0] dx,
                                         logic signed [DiffW-1:0] dy,
                                         logic [4:0] lim, logic [9:0] lim_sq);
    logic [DiffW-1:0] ax;
    logic [DiffW-1:0] ay;
    logic [9:0]       sqx;
    logic [9:0]       sqy;
    logic [10:0]      sum;
    ax  = magnitude(dx);
    ay  = magnitude(dy);
    sqx = {5'b0, ax[4:0]} * {5'b0, ax[4:0]};
    sqy = {5'b0, ay[4:0]} * {5'b0, ay[4:0]};
    sum = {1'b0, sqx} + {1'b0, sqy};
    if ((ax >= DiffW'(lim)) || (ay >= DiffW'(lim))) begin
      return 1'b0;
    end
    return sum < {1'b0, lim_sq};
  endfunction

  // movement from oldest to newest entry
  function automatic gesture_e classify(logic signed [DiffW-1:0] dx,
                                        logic signed [DiffW-1:0] dy);
    gesture_e g;
    if (within_radius(dx, dy, StillLim, StillLimSq)) begin
      g = GEST_STABLE;
    end else if (magnitude(dx) > magnitude(dy)) begin
      g = (!dx[DiffW-1] && (dx != '0)) ? GEST_RIGHT : GEST_LEFT;
    end else begin
      g = (!dy[DiffW-1] && (dy != '0)) ? GEST_DOWN : GEST_UP;
    end
    return g;
  endfunction

endpackage

[hdl/hdst_cell.sv]
// one history cell: holds a position and passes it to its neighbor on each shift
module hdst_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  hdst_pkg::pos_t  pos_i,
  output hdst_pkg::pos_t  pos_o
);

  hdst_pkg::pos_t pos_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pos_q <= pos_i;
    end
  end

  assign pos_o = pos_q;

endmodule

[hdl/hdst_out_buf.sv]
// two-entry result buffer: output register plus skid slot
module hdst_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hdst_pkg::res_t  res_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output hdst_pkg::res_t  res_o
);

  logic           head_vld_q, head_vld_d;
  logic           skid_vld_q, skid_vld_d;
  hdst_pkg::res_t head_q, head_d;
  hdst_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign pop = head_vld_q && !out_stall_i;

  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (!head_vld_q) begin
      if (push_i) begin
        head_d     = res_i;
        head_vld_d = 1'b1;
      end
    end else if (!skid_vld_q) begin
      if (pop && push_i) begin
        head_d = res_i;
      end else if (pop) begin
        head_vld_d = 1'b0;
      end else if (push_i) begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      head_d     = skid_q;
      skid_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign res_o       = head_q;

endmodule

[hdl/hand_dwell_and_swipe_tracker_top.sv]
// top level of the hand dwell and swipe tracker
//
// takes one hand position per request (hand_x_i, hand_y_i, -1 in either
// coordinate meaning no hand) and returns one result per request: the dwell
// trigger flag and a swipe gesture code. a request is taken in every cycle in
// which in_valid_i is high and in_stall_o is low, so the sustained rate is
// one request per clock while out_stall_i is low. the history of recent
// positions lives in a chain of HISTORY_DEPTH-1 shifting cells plus one
// register for the oldest entry; all per-request math (step check against
// the newest cell, dwell counter update, oldest-to-newest classification)
// is combinational on the accepted request. a two-entry result buffer lets
// a new request in while an earlier result is still held; in_stall_o rises
// only when both entries are waiting. the threshold port is always ready and
// clamps written values to 10..100; write it only while idle.

module hand_dwell_and_swipe_tracker_top #(
  parameter int unsigned HISTORY_DEPTH = 10,
  parameter int unsigned MIN_HISTORY   = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // position requests
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [hdst_pkg::CoordW-1:0]     hand_x_i,
  input  logic signed [hdst_pkg::CoordW-1:0]     hand_y_i,
  // results
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   trigger_ready_o,
  output logic [2:0]                             gesture_o,
  // threshold register write
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [hdst_pkg::ThrW-1:0]              cfg_data_i
);

  localparam int unsigned CntW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned Chain  = HISTORY_DEPTH - 1;

  // history fill level, saturates at HISTORY_DEPTH
  logic [CntW-1:0] count_q, count_d;
  logic [hdst_pkg::ThrW-1:0] dwell_q, dwell_d;
  logic                      flag_q, flag_d;
  logic [hdst_pkg::ThrW-1:0] thr_q;

  hdst_pkg::pos_t new_pos;
  hdst_pkg::pos_t cell_q [Chain];
  hdst_pkg::pos_t oldest_q, oldest_d;

  logic accept;
  logic present;
  logic stable;
  logic hist_empty;
  logic hist_full;
  logic [hdst_pkg::ThrW-1:0] dwell_inc;
  logic signed [hdst_pkg::DiffW-1:0] step_dx, step_dy;
  logic signed [hdst_pkg::DiffW-1:0] move_dx, move_dy;
  hdst_pkg::res_t res;
  hdst_pkg::res_t res_out;
  logic           buf_full;

  assign accept     = in_valid_i && !in_stall_o;
  assign new_pos.x  = hand_x_i;
  assign new_pos.y  = hand_y_i;
  assign hist_empty = (count_q == '0);
  assign hist_full  = (count_q == CntW'(HISTORY_DEPTH));

  // shift chain of history cells, newest in cell 0
  for (genvar k = 0; k < Chain; k++) begin : g_cell
    if (k == 0) begin : g_head
      hdst_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .pos_i   (new_pos),
        .pos_o   (cell_q[k])
      );
    end else begin : g_body
      hdst_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .pos_i   (cell_q[k-1]),
        .pos_o   (cell_q[k])
      );
    end
  end

  // oldest entry: first write ever, then whatever drops off the chain end
  always_comb begin
    oldest_d = oldest_q;
    if (hist_empty) begin
      oldest_d = new_pos;
    end else if (hist_full) begin
      oldest_d = cell_q[Chain-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      oldest_q <= oldest_d;
    end
  end

  // step check against newest stored position
  assign present = (hand_x_i != '1) && (hand_y_i != '1);
  assign step_dx = hdst_pkg::coord_diff(cell_q[0].x, hand_x_i);
  assign step_dy = hdst_pkg::coord_diff(cell_q[0].y, hand_y_i);
  assign stable  = present && (hist_empty ||
                   hdst_pkg::within_radius(step_dx, step_dy,
                                           hdst_pkg::StepLim, hdst_pkg::StepLimSq));

  // dwell counter, saturating
  assign dwell_inc = (dwell_q == hdst_pkg::DwellMax) ? dwell_q
                                                     : dwell_q + hdst_pkg::ThrW'(1);

  always_comb begin
    if (stable) begin
      dwell_d = dwell_inc;
      flag_d  = flag_q || (dwell_inc >= thr_q);
    end else begin
      dwell_d = '0;
      flag_d  = 1'b0;
    end
  end

  assign count_d = hist_full ? count_q : count_q + CntW'(1);

  // classification from oldest to newest after this push
  assign move_dx = hdst_pkg::coord_diff(oldest_d.x, hand_x_i);
  assign move_dy = hdst_pkg::coord_diff(oldest_d.y, hand_y_i);

  always_comb begin
    res.trigger_ready = flag_d;
    if (count_d >= CntW'(MIN_HISTORY)) begin
      res.gesture = hdst_pkg::classify(move_dx, move_dy);
    end else begin
      res.gesture = hdst_pkg::GEST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dwell_q <= '0;
      flag_q  <= 1'b0;
    end else if (accept) begin
      count_q <= count_d;
      dwell_q <= dwell_d;
      flag_q  <= flag_d;
    end
  end

  // threshold register, clamped on write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hdst_pkg::ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i < hdst_pkg::ThrMin) begin
        thr_q <= hdst_pkg::ThrMin;
      end else if (cfg_data_i > hdst_pkg::ThrMax) begin
        thr_q <= hdst_pkg::ThrMax;
      end else begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // result buffer
  hdst_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign in_stall_o      = buf_full;
  assign trigger_ready_o = res_out.trigger_ready;
  assign gesture_o       = res_out.gesture;

endmodule

[hdl/hdst_checker.sv]
// port-level checks for the hand dwell and swipe tracker, bound to the top level
module hdst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       trigger_ready_o,
  input logic [2:0] gesture_o
);

  // a held result stays put while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gesture_o) && $stable(trigger_ready_o))
    else $error("stalled result changed");

  // gesture code stays within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gesture_o <= hdst_pkg::GEST_UP))
    else $error("gesture code out of range");

  // input stall means both buffer entries hold results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // buffer fills only behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_stall_i))
    else $error("input stall without output stall");

endmodule

bind hand_dwell_and_swipe_tracker_top hdst_checker u_hdst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .trigger_ready_o (trigger_ready_o),
  .gesture_o       (gesture_o)
);

[tb/hand_dwell_and_swipe_tracker_top_tb.sv]
// testbench for the hand tracker: directed position table, then random dwell and swipe traffic
`timescale 1ns / 1ps
module hand_dwell_and_swipe_tracker_top_tb;

  localparam int unsigned HISTORY_DEPTH   = 10;
  localparam int unsigned MIN_HISTORY     = 5;
  localparam int          STEP_LIMIT_SQ   = 400;  // squared step below this counts as still
  localparam int          STILL_LIMIT_SQ  = 900;  // squared travel below this is no swipe
  localparam int          ITEMS_PER_PHASE = 170;
  localparam int          PHASES          = 8;
  localparam int          LONG_HOLD       = 120;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          RESET_CYCLES    = 11;
  localparam int          CYCLE_LIMIT     = 400000;

  localparam logic signed [hdst_pkg::CoordW-1:0] NO_HAND   = -13'sd1;
  localparam logic signed [hdst_pkg::CoordW-1:0] COORD_MAX = 13'sd4095;
  localparam logic signed [hdst_pkg::CoordW-1:0] COORD_MIN = 13'sh1000;

  localparam hdst_pkg::res_t NO_CLAIM = '{1'b0, hdst_pkg::GEST_NONE};

  // one row of the opening table; typed rows carry a result read straight off the spec
  typedef struct packed {
    logic signed [hdst_pkg::CoordW-1:0] x;
    logic signed [hdst_pkg::CoordW-1:0] y;
    logic                               typed;
    hdst_pkg::res_t                     want;
  } opening_row_t;

  localparam int OPENING_ROWS = 23;
  localparam opening_row_t OPENING [OPENING_ROWS] = '{
    '{NO_HAND,   NO_HAND,   1'b1, '{1'b0, hdst_pkg::GEST_NONE}},    // nothing seen at all
    '{13'sd0,    13'sd0,    1'b1, '{1'b0, hdst_pkg::GEST_NONE}},    // tiny step, dwell 1 of 30
    '{COORD_MAX, COORD_MAX, 1'b1, '{1'b0, hdst_pkg::GEST_NONE}},    // far corner jump
    '{COORD_MIN, COORD_MAX, 1'b1, '{1'b0, hdst_pkg::GEST_NONE}},    // most negative column
    '{COORD_MAX, NO_HAND,   1'b1, '{1'b0, hdst_pkg::GEST_RIGHT}},   // classify depth reached
    '{NO_HAND,   COORD_MAX, 1'b1, '{1'b0, hdst_pkg::GEST_DOWN}},
    '{NO_HAND,   NO_HAND,   1'b1, '{1'b0, hdst_pkg::GEST_STABLE}},  // back where it started
    '{COORD_MIN, NO_HAND,   1'b1, '{1'b0, hdst_pkg::GEST_LEFT}},
    '{NO_HAND,   COORD_MIN, 1'b1, '{1'b0, hdst_pkg::GEST_UP}},
    '{13'sd29,   13'sd29,   1'b1, '{1'b0, hdst_pkg::GEST_DOWN}},    // equal axes go vertical
    '{13'sd21,   13'sd0,    1'b1, '{1'b0, hdst_pkg::GEST_STABLE}},  // oldest drops out
    '{13'sd41,   13'sd0,    1'b0, NO_CLAIM},              // step of exactly 20
    '{13'sd53,   13'sd16,   1'b0, NO_CLAIM},              // step 12/16, right on the limit
    '{13'sd65,   13'sd31,   1'b0, NO_CLAIM},              // step 12/15, just inside
    '{13'sd65,   13'sd50,   1'b0, NO_CLAIM},
    '{-13'sd2,   -13'sd2,   1'b0, NO_CLAIM},              // negative but not the no-hand code
    '{-13'sd2,   -13'sd3,   1'b0, NO_CLAIM},
    '{NO_HAND,   13'sd5,    1'b0, NO_CLAIM},              // only the column missing
    '{13'sd7,    NO_HAND,   1'b0, NO_CLAIM},              // only the row missing
    '{13'sd7,    13'sd5,    1'b0, NO_CLAIM},              // step measured from a no-hand entry
    '{13'sd2730, 13'sd1365, 1'b0, NO_CLAIM},
    '{13'sd1365, 13'sd2730, 1'b0, NO_CLAIM},
    '{COORD_MAX, 13'sd0,    1'b0, NO_CLAIM}
  };

  // dut ports
  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_stall_o;
  logic signed [hdst_pkg::CoordW-1:0] hand_x_i    = '0;
  logic signed [hdst_pkg::CoordW-1:0] hand_y_i    = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic                               trigger_ready_o;
  logic [2:0]                         gesture_o;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [hdst_pkg::ThrW-1:0]          cfg_data_i  = '0;

  // travels with each request: whether the table already states its result
  logic           row_typed = 1'b0;
  hdst_pkg::res_t row_want  = NO_CLAIM;

  // tracker model state
  logic signed [hdst_pkg::CoordW-1:0] trail_x [HISTORY_DEPTH];
  logic signed [hdst_pkg::CoordW-1:0] trail_y [HISTORY_DEPTH];
  int unsigned                        trail_len = 0;
  logic [hdst_pkg::ThrW-1:0]          dwell_run = '0;
  logic                               armed     = 1'b0;
  logic [hdst_pkg::ThrW-1:0]          thr_now   = hdst_pkg::ThrReset;

  hdst_pkg::res_t pending_results [$];
  int          sent_count    = 0;
  int          checked_count = 0;
  int          mismatches    = 0;
  int          calm_left     = 0;
  bit          hold_request  = 1'b0;
  int unsigned cycle_count   = 0;

  hand_dwell_and_swipe_tracker_top #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .MIN_HISTORY  (MIN_HISTORY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .hand_x_i       (hand_x_i),
    .hand_y_i       (hand_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trigger_ready_o(trigger_ready_o),
    .gesture_o      (gesture_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hard stop in case a result never shows up
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // advance the tracker by one position and return the flag and swipe it should report
  function automatic hdst_pkg::res_t track_position(logic signed [hdst_pkg::CoordW-1:0] x,
                                                    logic signed [hdst_pkg::CoordW-1:0] y);
    hdst_pkg::res_t r;
    bit   hand_seen;
    bit   still;
    int   px;
    int   py;
    int   dx;
    int   dy;
    int   ax;
    int   ay;
    px = x;
    py = y;
    hand_seen = (x != NO_HAND) && (y != NO_HAND);
    still = 1'b0;
    if (hand_seen) begin
      if (trail_len == 0) begin
        still = 1'b1;
      end else begin
        dx = px - int'(trail_x[trail_len-1]);
        dy = py - int'(trail_y[trail_len-1]);
        still = (dx * dx + dy * dy) < STEP_LIMIT_SQ;
      end
    end
    if (still) begin
      if (dwell_run < hdst_pkg::DwellMax) dwell_run++;
      if (dwell_run >= thr_now) armed = 1'b1;
    end else begin
      dwell_run = '0;
      armed = 1'b0;
    end
    // every position goes into the history, absent ones too
    if (trail_len == HISTORY_DEPTH) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        trail_x[i] = trail_x[i+1];
        trail_y[i] = trail_y[i+1];
      end
      trail_len = HISTORY_DEPTH - 1;
    end
    trail_x[trail_len] = x;
    trail_y[trail_len] = y;
    trail_len++;
    r.trigger_ready = armed;
    r.gesture = hdst_pkg::GEST_NONE;
    if (trail_len >= MIN_HISTORY) begin
      dx = int'(trail_x[trail_len-1]) - int'(trail_x[0]);
      dy = int'(trail_y[trail_len-1]) - int'(trail_y[0]);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (dx * dx + dy * dy < STILL_LIMIT_SQ) r.gesture = hdst_pkg::GEST_STABLE;
      else if (ax > ay) r.gesture = (dx > 0) ? hdst_pkg::GEST_RIGHT : hdst_pkg::GEST_LEFT;
      else r.gesture = (dy > 0) ? hdst_pkg::GEST_DOWN : hdst_pkg::GEST_UP;
    end
    return r;
  endfunction

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic log_mismatch(string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // scoreboard: threshold writes and accepted requests feed the model,
  // every accepted result is held against the oldest expectation
  always @(posedge clk_i) begin : scoreboard
    hdst_pkg::res_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_data_i < hdst_pkg::ThrMin) thr_now = hdst_pkg::ThrMin;
        else if (cfg_data_i > hdst_pkg::ThrMax) thr_now = hdst_pkg::ThrMax;
        else thr_now = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        want = track_position(hand_x_i, hand_y_i);
        if (row_typed) want = row_want;
        pending_results = {pending_results, want};
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("result with no request waiting: trigger %0b gesture %0d",
                                 trigger_ready_o, gesture_o));
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (trigger_ready_o !== want.trigger_ready)
            log_mismatch($sformatf("result %0d trigger_ready %b, want %b", checked_count,
                                   trigger_ready_o, want.trigger_ready));
          if (gesture_o !== want.gesture)
            log_mismatch($sformatf("result %0d gesture %0d, want %0d", checked_count,
                                   gesture_o, want.gesture));
        end
      end
    end
  end

  // result side: random stalls, calm stretches, and one long hold when asked
  initial begin : result_sink
    int stall_run;
    int free_run;
    stall_run = 0;
    free_run = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_run = LONG_HOLD;
      end else if (stall_run == 0 && free_run == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          free_run = $urandom_range(20, 60);
        end else begin
          stall_run = idle_len();
          free_run = $urandom_range(1, 5);
        end
      end
      if (stall_run > 0) begin
        out_stall_i <= 1'b1;
        stall_run--;
      end else begin
        out_stall_i <= 1'b0;
        if (free_run > 0) free_run--;
      end
    end
  end

  // offer one position request and hold it until the block takes it
  task automatic offer_position(logic signed [hdst_pkg::CoordW-1:0] x,
                                logic signed [hdst_pkg::CoordW-1:0] y,
                                logic typed = 1'b0, hdst_pkg::res_t want = NO_CLAIM);
    int idle;
    idle = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      idle = idle_len();
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 80);
    end
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hand_x_i   <= x;
    hand_y_i   <= y;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
  endtask

  // stop sending until every outstanding result is back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    wait (checked_count == sent_count);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [hdst_pkg::ThrW-1:0] value);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // one burst of hand motion: a dwell, a swipe, a hold-then-move probe, or junk
  task automatic run_sequence();
    int kind;
    int len;
    int px;
    int py;
    int dx;
    int dy;
    int speed;
    int r;
    bit clean;
    kind = $urandom_range(0, 99);
    px = $urandom_range(200, 3900);
    py = $urandom_range(200, 3900);
    if (kind < 40) begin
      // dwell: long runs stay clean so high thresholds and saturation get reached
      clean = ($urandom_range(0, 2) == 0);
      len = clean ? $urandom_range(100, 140) : $urandom_range(3, 40);
      repeat (len) begin
        r = clean ? 0 : $urandom_range(0, 99);
        if (r < 85) begin
          px += int'($urandom_range(0, 26)) - 13;
          py += int'($urandom_range(0, 26)) - 13;
          offer_position(hdst_pkg::CoordW'(px), hdst_pkg::CoordW'(py));
        end else if (r < 93) begin
          // steps on or right next to the stillness limit
          case ($urandom_range(0, 3))
            0: begin dx = 20; dy = 0;  end
            1: begin dx = 12; dy = 16; end
            2: begin dx = 16; dy = 12; end
            default: begin dx = 14; dy = 14; end
          endcase
          if ($urandom_range(0, 1) == 1) dx = -dx;
          if ($urandom_range(0, 1) == 1) dy = -dy;
          px += dx;
          py += dy;
          offer_position(hdst_pkg::CoordW'(px), hdst_pkg::CoordW'(py));
        end else if (r < 97) begin
          case ($urandom_range(0, 2))
            0: offer_position(NO_HAND, hdst_pkg::CoordW'(py));
            1: offer_position(hdst_pkg::CoordW'(px), NO_HAND);
            default: offer_position(NO_HAND, NO_HAND);
          endcase
        end else begin
          px = $urandom_range(0, 4095);
          py = $urandom_range(0, 4095);
          offer_position(hdst_pkg::CoordW'(px), hdst_pkg::CoordW'(py));
        end
      end
    end else if (kind < 70) begin
      // swipe along one axis with a little wobble on both
      len = $urandom_range(5, 14);
      speed = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(3, 19);
      if ($urandom_range(0, 1) == 1) speed = -speed;
      dx = 0;
      dy = 0;
      if ($urandom_range(0, 1) == 1) dx = speed;
      else dy = speed;
      repeat (len) begin
        px += dx + int'($urandom_range(0, 6)) - 3;
        py += dy + int'($urandom_range(0, 6)) - 3;
        offer_position(hdst_pkg::CoordW'(px), hdst_pkg::CoordW'(py));
      end
    end else if (kind < 80) begin
      // fill the history with one point, then move near the swipe radius
      repeat (HISTORY_DEPTH - 1) offer_position(hdst_pkg::CoordW'(px), hdst_pkg::CoordW'(py));
      case ($urandom_range(0, 7))
        0: begin dx = 30; dy = 0;  end
        1: begin dx = 0;  dy = 30; end
        2: begin dx = 18; dy = 24; end
        3: begin dx = 24; dy = 18; end
        4: begin dx = 29; dy = 0;  end
        5: begin dx = 21; dy = 21; end
        6: begin dx = 25; dy = 25; end
        default: begin
          dx = $urandom_range(0, 31);
          dy = $urandom_range(0, 31);
        end
      endcase
      if ($urandom_range(0, 1) == 1) dx = -dx;
      if ($urandom_range(0, 1) == 1) dy = -dy;
      offer_position(hdst_pkg::CoordW'(px + dx), hdst_pkg::CoordW'(py + dy));
    end else begin
      // junk over the whole field range, no-hand codes mixed in
      repeat ($urandom_range(1, 6)) begin
        offer_position(($urandom_range(0, 4) == 0) ? NO_HAND : hdst_pkg::CoordW'($urandom),
                       ($urandom_range(0, 4) == 0) ? NO_HAND : hdst_pkg::CoordW'($urandom));
      end
    end
  endtask

  // threshold per phase: clamped extremes, in-range extremes, just outside; last phase random
  logic [hdst_pkg::ThrW-1:0] threshold_plan [PHASES-1] = '{7'd0, 7'd127, 7'd10, 7'd100,
                                                           7'd9, 7'd101, 7'd55};

  initial begin : stimulus
    int phase_start;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening table under the reset threshold
    foreach (OPENING[i]) begin
      offer_position(OPENING[i].x, OPENING[i].y, OPENING[i].typed, OPENING[i].want);
    end

    // first random phase keeps the reset threshold, the rest write a new one
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) write_threshold(hdst_pkg::ThrW'($urandom));
      else if (p > 0) write_threshold(threshold_plan[p-1]);
      // result side goes quiet for a while so the request side backs up
      if (p == 1 || p == 4) hold_request = 1'b1;
      phase_start = sent_count;
      while (sent_count - phase_start < ITEMS_PER_PHASE) run_sequence();
    end

    wait_for_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
